>>> hw/rtl/svx_pkg.sv
// Shared constants, codes and control/status types of the style vector crossfade block.
package svx_pkg;

    localparam int STYLES    = 16;
    localparam int ELEMS     = 64;
    localparam int DATA_BITS = 16;

    localparam int STYLE_W = 4;
    localparam int ELEM_W  = 6;
    localparam int ADDR_W  = $clog2(STYLES * ELEMS);
    localparam int WORD_W  = 2 * DATA_BITS;
    localparam int CFG_W   = 17;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [1:0] FUNC_FRAME   = 2'd2;

    localparam logic [1:0] CFG_STYLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_TRANS_FRAMES = 2'd1;
    localparam logic [1:0] CFG_ALPHA_STEP  = 2'd2;

    typedef struct packed {
        logic load;
        logic advance;
        logic frame;
        logic issue;
    } t_ctl_cmd;

    typedef struct packed {
        logic loaded;
        logic elem_last;
        logic pipe_fill;
    } t_dp_stat;

endpackage

>>> hw/rtl/style_vector_crossfade.sv
// Top level of the style vector crossfade block: controller plus datapath.
// A load or advance word leaves busy low, and the next word may follow at once.
// A frame request, taken only once a load word has been accepted, holds busy high while its
// elements are issued and drained; one element follows per cycle, and no new word is
// accepted until busy falls again. Results cannot be stalled. Synchronous active-low reset
// clears the state machine, style state, configuration and valid registers; the payload
// registers and style table are not cleared; the table holds undefined data until written.
module style_vector_crossfade import svx_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_func,
    input  logic [STYLE_W-1:0]   i_load_style,
    input  logic [ELEM_W-1:0]    i_load_element,
    input  logic [DATA_BITS-1:0] i_mean_value,
    input  logic [DATA_BITS-1:0] i_std_value,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_strobe,
    output logic [DATA_BITS-1:0] o_mean_out,
    output logic [DATA_BITS-1:0] o_std_out,
    output logic [ELEM_W-1:0]    o_out_element,
    output logic                 o_last_element
);

    // The controller decodes each accepted word and, for a frame request, walks the
    // element counter through the table; the datapath owns every stored value.
    t_ctl_cmd cmd;
    t_dp_stat stat;

    svx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // The datapath reads the current and previous style entries in parallel from two
    // copies of the table; in a transition it weights both, rounds and saturates, else passes the current one.
    svx_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_load_style   (i_load_style),
        .i_load_element (i_load_element),
        .i_mean_value   (i_mean_value),
        .i_std_value    (i_std_value),
        .o_strobe       (o_strobe),
        .o_mean_out     (o_mean_out),
        .o_std_out      (o_std_out),
        .o_out_element  (o_out_element),
        .o_last_element (o_last_element)
    );

endmodule

>>> hw/rtl/svx_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module svx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/svx_ctrl.sv
// Controller state machine: decodes commands and sequences the element run of a frame.
module svx_ctrl import svx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_func,
    input  t_dp_stat   i_stat,
    output t_ctl_cmd   o_cmd,
    output logic       o_busy
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        FUNC_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        FUNC_ADVANCE: begin
                            o_cmd.advance = i_stat.loaded;
                        end
                        FUNC_FRAME: begin
                            if (i_stat.loaded) begin
                                o_cmd.frame = 1'b1;
                                n_state     = ST_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.elem_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_fill) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

>>> hw/rtl/svx_dp.sv
// Datapath: style table, style state, weight and the blend pipeline.
module svx_dp import svx_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl_cmd             i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [STYLE_W-1:0]   i_load_style,
    input  logic [ELEM_W-1:0]    i_load_element,
    input  logic [DATA_BITS-1:0] i_mean_value,
    input  logic [DATA_BITS-1:0] i_std_value,
    output logic                 o_strobe,
    output logic [DATA_BITS-1:0] o_mean_out,
    output logic [DATA_BITS-1:0] o_std_out,
    output logic [ELEM_W-1:0]    o_out_element,
    output logic                 o_last_element
);

    localparam int PROD_W = DATA_BITS + 18;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RES_W  = SUM_W - 16;

    // Configuration registers
    logic [4:0]  r_style_count;
    logic [7:0]  r_trans_frames;
    logic [16:0] r_alpha_step;

    // Style state
    logic [STYLE_W-1:0] r_cur_style, r_prev_style;
    logic [7:0]         r_frame_count;
    logic               r_in_trans;
    logic               r_loaded;

    // Run snapshot
    logic [STYLE_W-1:0] r_run_cur, r_run_prev;
    logic               r_run_blend;
    logic [16:0]        r_w;
    logic [ELEM_W-1:0]  r_elem;

    // Pipeline
    logic                      r_v1, r_v2, r_v3;
    logic [ELEM_W-1:0]         r_e1, r_e2, r_e3;
    logic                      r_l1, r_l2, r_l3;
    logic signed [PROD_W-1:0]  r_pm_a, r_pm_b, r_ps_a, r_ps_b;
    logic [DATA_BITS-1:0]      r_cm, r_cs;
    logic                      r_b2;
    logic [DATA_BITS-1:0]      r_mean_o, r_std_o;

    logic [4:0]           cnt_clamped;
    logic [4:0]           next_style;
    logic [24:0]          w_prod;
    logic [16:0]          w_sat;
    logic [8:0]           fc_inc;
    logic                 load_in_range;
    logic [ADDR_W-1:0]    waddr, raddr_cur, raddr_prev;
    logic [WORD_W-1:0]    cur_q, prev_q;
    logic [16:0]          w_inv;
    logic signed [17:0]   w_s, w_inv_s;

    function automatic logic [DATA_BITS-1:0] round_sat(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b
    );
        logic signed [SUM_W-1:0] t;
        logic signed [RES_W-1:0] r;
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        hi = RES_W'((2 ** (DATA_BITS - 1)) - 1);
        lo = -hi - RES_W'(1);
        t  = SUM_W'(a) + SUM_W'(b) + SUM_W'(32768);
        r  = RES_W'(t >>> 16);
        if (r > hi) begin
            r = hi;
        end else if (r < lo) begin
            r = lo;
        end
        return DATA_BITS'(r);
    endfunction

    // Wrap point and next style
    always_comb begin
        if (r_style_count == 5'd0) begin
            cnt_clamped = 5'd1;
        end else if (int'(r_style_count) > STYLES) begin
            cnt_clamped = 5'(STYLES);
        end else begin
            cnt_clamped = r_style_count;
        end
        next_style = {1'b0, r_cur_style} + 5'd1;
        if (next_style >= cnt_clamped) begin
            next_style = 5'd0;
        end
    end

    assign w_prod = r_alpha_step * {17'd0, r_frame_count};
    assign w_sat  = (w_prod > 25'(ONE_Q16)) ? ONE_Q16 : w_prod[16:0];
    assign fc_inc = {1'b0, r_frame_count} + 9'd1;

    assign load_in_range = (int'(i_load_style) < STYLES) && (int'(i_load_element) < ELEMS);
    assign waddr      = ADDR_W'(ADDR_W'(i_load_style) * ADDR_W'(ELEMS) + ADDR_W'(i_load_element));
    assign raddr_cur  = ADDR_W'(ADDR_W'(r_run_cur) * ADDR_W'(ELEMS) + ADDR_W'(r_elem));
    assign raddr_prev = ADDR_W'(ADDR_W'(r_run_prev) * ADDR_W'(ELEMS) + ADDR_W'(r_elem));

    svx_ram #(.WIDTH(WORD_W), .DEPTH(STYLES * ELEMS)) u_ram_cur (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && load_in_range),
        .i_waddr (waddr),
        .i_wdata ({i_mean_value, i_std_value}),
        .i_raddr (raddr_cur),
        .o_rdata (cur_q)
    );

    svx_ram #(.WIDTH(WORD_W), .DEPTH(STYLES * ELEMS)) u_ram_prev (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && load_in_range),
        .i_waddr (waddr),
        .i_wdata ({i_mean_value, i_std_value}),
        .i_raddr (raddr_prev),
        .o_rdata (prev_q)
    );

    assign w_inv   = ONE_Q16 - r_w;
    assign w_s     = signed'({1'b0, r_w});
    assign w_inv_s = signed'({1'b0, w_inv});

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style_count  <= 5'd1;
            r_trans_frames <= 8'd1;
            r_alpha_step   <= ONE_Q16;
            r_cur_style    <= '0;
            r_prev_style   <= '0;
            r_frame_count  <= 8'd1;
            r_in_trans     <= 1'b0;
            r_loaded       <= 1'b0;
            r_elem         <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_STYLE_COUNT:  r_style_count  <= i_cfg_data[4:0];
                    CFG_TRANS_FRAMES: r_trans_frames <= i_cfg_data[7:0];
                    CFG_ALPHA_STEP:   r_alpha_step   <= i_cfg_data[16:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_loaded <= 1'b1;
            end
            if (i_cmd.advance) begin
                r_cur_style <= next_style[STYLE_W-1:0];
                r_in_trans  <= 1'b1;
            end
            if (i_cmd.frame && r_in_trans) begin
                if (fc_inc > {1'b0, r_trans_frames}) begin
                    r_frame_count <= 8'd1;
                    r_in_trans    <= 1'b0;
                    r_prev_style  <= r_cur_style;
                end else begin
                    r_frame_count <= fc_inc[7:0];
                end
            end
            if (i_cmd.issue) begin
                r_elem <= (int'(r_elem) == ELEMS - 1) ? '0 : r_elem + ELEM_W'(1);
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload: run snapshot and pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame) begin
            r_run_cur   <= r_cur_style;
            r_run_prev  <= r_prev_style;
            r_run_blend <= r_in_trans;
            r_w         <= w_sat;
        end
        r_e1 <= r_elem;
        r_l1 <= (int'(r_elem) == ELEMS - 1);

        r_e2   <= r_e1;
        r_l2   <= r_l1;
        r_b2   <= r_run_blend;
        r_cm   <= cur_q[WORD_W-1:DATA_BITS];
        r_cs   <= cur_q[DATA_BITS-1:0];
        r_pm_a <= signed'(prev_q[WORD_W-1:DATA_BITS]) * w_inv_s;
        r_pm_b <= signed'(cur_q[WORD_W-1:DATA_BITS]) * w_s;
        r_ps_a <= signed'(prev_q[DATA_BITS-1:0]) * w_inv_s;
        r_ps_b <= signed'(cur_q[DATA_BITS-1:0]) * w_s;

        r_e3 <= r_e2;
        r_l3 <= r_l2;
        if (r_b2) begin
            r_mean_o <= round_sat(r_pm_a, r_pm_b);
            r_std_o  <= round_sat(r_ps_a, r_ps_b);
        end else begin
            r_mean_o <= r_cm;
            r_std_o  <= r_cs;
        end
    end

    assign o_stat.loaded    = r_loaded;
    assign o_stat.elem_last = (int'(r_elem) == ELEMS - 1);
    assign o_stat.pipe_fill = r_v1 || r_v2;

    assign o_strobe       = r_v3;
    assign o_mean_out     = r_mean_o;
    assign o_std_out      = r_std_o;
    assign o_out_element  = r_e3;
    assign o_last_element = r_l3;

endmodule
